[rtl/cos_cubed_beam_gain_unit_assert.svh]
// Assertion macros for the cos^3 beam gain unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef COS_CUBED_BEAM_GAIN_UNIT_ASSERT_SVH
`define COS_CUBED_BEAM_GAIN_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CCBG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccbg assertion failed");
`define CCBG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccbg assertion failed");
`else
`define CCBG_ASSERT_IMP(lbl, ante, cons)
`define CCBG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/ccbg_pkg.sv]
`timescale 1ns / 1ps
package ccbg_pkg;

  // CORDIC step count, 12..24
  localparam int unsigned COS_ITERATIONS = 18;
  localparam int unsigned ROT_LEN = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BEAM_FACTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_L     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_M     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ELL_EN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELL_X       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ELL_Y       = 3'd7;

  localparam logic [1:0] CLIP_NONE  = 2'd0;
  localparam logic [1:0] CLIP_ARG   = 2'd1;
  localparam logic [1:0] CLIP_FLOOR = 2'd2;

  localparam int unsigned W_W       = 17;
  localparam int unsigned DIV_STEPS = 17;
  localparam logic [W_W-1:0] W_ONE  = 17'd16384;

  localparam int unsigned PROD_W   = 64;
  localparam int unsigned R2_W     = 52;
  localparam int unsigned R_W      = 26;
  localparam int unsigned SQ_STEPS = 26;
  localparam int unsigned THETA_W  = 45;
  localparam int unsigned MOD_STEPS = 19;
  localparam int unsigned A_W      = 27;
  localparam int unsigned CW       = 34;

  localparam logic [A_W-1:0] TWO_PI_Q24  = 27'd105414358;
  localparam logic [A_W-1:0] PI_Q24      = 27'd52707179;
  localparam logic [A_W-1:0] HALF_PI_Q24 = 27'd26353589;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [31:0] ROT_ANGLE [ROT_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  typedef struct packed {
    logic              busy;
    logic [3:0][W_W-1:0] w;   // +ex, -ex, +ey, -ey
  } ccbg_wgt_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [17:0] value;
  } ccbg_clip_t;

endpackage

[rtl/ccbg_if.sv]
`timescale 1ns / 1ps
interface ccbg_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] source_l;
  logic signed [23:0] source_m;
  logic [31:0]        frequency_hz;
  modport source (output valid, source_l, source_m, frequency_hz, input ready);
  modport sink (input valid, source_l, source_m, frequency_hz, output ready);
endinterface

interface ccbg_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] beam_x;
  logic signed [17:0] beam_y;
  modport source (output valid, beam_x, beam_y, input ready);
  modport sink (input valid, beam_x, beam_y, output ready);
endinterface

[rtl/ccbg_wgen.sv]
`timescale 1ns / 1ps
module ccbg_wgen import ccbg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] ex_i,
  input  logic signed [15:0] ey_i,
  output ccbg_wgt_t          wgt_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  function automatic logic signed [15:0] sat_e(input logic signed [15:0] e);
    if (e < -16'sd16384) begin
      return -16'sd16384;
    end else if (e > 16'sd16384) begin
      return 16'sd16384;
    end
    return e;
  endfunction

  logic [1:0]          state_q;
  logic [1:0]          sel_q;
  logic [4:0]          cnt_q;
  logic [3:0][W_W-1:0] w_q;
  logic [31:0]         d2_q;
  logic [32:0]         rem_q;
  logic [W_W-1:0]      nl_q;

  logic signed [15:0] e_sel;
  logic signed [16:0] d17;
  logic [15:0]        d16;
  logic [44:0]        num;
  logic [32:0]        trial;
  logic               ge;
  logic [32:0]        rem_nx;
  logic [W_W-1:0]     nl_nx;

  always_comb begin
    e_sel  = sel_q[1] ? sat_e(ey_i) : sat_e(ex_i);
    d17    = sel_q[0] ? 17'sd32768 - 17'(e_sel) : 17'sd32768 + 17'(e_sel);
    d16    = d17[15:0];
    num    = (45'd1 << 44) + 45'(d2_q >> 1);
    trial  = {rem_q[31:0], nl_q[W_W-1]};
    ge     = trial >= {1'b0, d2_q};
    rem_nx = ge ? trial - {1'b0, d2_q} : trial;
    nl_nx  = {nl_q[W_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 2'd0;
      cnt_q   <= 5'd0;
      w_q     <= {4{W_ONE}};
    end else if (start_i) begin
      state_q <= ST_SQ;
      sel_q   <= 2'd0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
        end
        ST_SQ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          state_q <= ST_DIV;
          cnt_q   <= 5'd0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(DIV_STEPS - 1)) begin
            w_q[sel_q] <= nl_nx;
            if (sel_q == 2'd3) begin
              state_q <= ST_IDLE;
            end else begin
              sel_q   <= sel_q + 2'd1;
              state_q <= ST_SQ;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQ) begin
      d2_q <= 32'(d16 * d16);
    end
    if (state_q == ST_LOAD) begin
      rem_q <= 33'(num >> DIV_STEPS);
      nl_q  <= num[W_W-1:0];
    end
    if (state_q == ST_DIV) begin
      rem_q <= rem_nx;
      nl_q  <= nl_nx;
    end
  end

  assign wgt_o.busy = state_q != ST_IDLE;
  assign wgt_o.w    = w_q;

endmodule

[rtl/ccbg_lane.sv]
`timescale 1ns / 1ps
module ccbg_lane import ccbg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [R2_W-1:0]    r2_i,
  input  logic [PROD_W-1:0]  prod_i,
  input  ccbg_clip_t         clip_i,
  output logic               valid_o,
  output logic signed [17:0] gain_o
);

  // square root, one result bit per stage
  logic              sv_q    [SQ_STEPS];
  logic [R2_W-1:0]   srem_q  [SQ_STEPS];
  logic [R2_W-1:0]   sres_q  [SQ_STEPS];
  logic [PROD_W-1:0] sprod_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [R2_W-1:0] Bit = R2_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic              vld;
    logic [R2_W-1:0]   vin;
    logic [R2_W-1:0]   rin;
    logic [R2_W-1:0]   trial;
    logic [PROD_W-1:0] pin;
    if (k == 0) begin : g_head
      assign vld = valid_i;
      assign vin = r2_i;
      assign rin = '0;
      assign pin = prod_i;
    end else begin : g_tail
      assign vld = sv_q[k-1];
      assign vin = srem_q[k-1];
      assign rin = sres_q[k-1];
      assign pin = sprod_q[k-1];
    end
    assign trial = rin + Bit;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en_i) begin
        sv_q[k] <= vld;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vin >= trial) begin
          srem_q[k] <= vin - trial;
          sres_q[k] <= (rin >> 1) + Bit;
        end else begin
          srem_q[k] <= vin;
          sres_q[k] <= rin >> 1;
        end
        sprod_q[k] <= pin;
      end
    end
  end

  // theta = beam_factor * freq * r, scaled
  logic [R_W-1:0]     r;
  logic               t1v_q, t2v_q;
  logic [57:0]        hi_q, lo_q;
  logic [THETA_W-1:0] th_q;
  logic [THETA_W-1:0] lim;
  logic [THETA_W-1:0] th_clip;

  assign r = sres_q[SQ_STEPS-1][R_W-1:0];
  assign lim = THETA_W'({clip_i.value, 8'b0});
  assign th_clip = (clip_i.mode == CLIP_ARG && clip_i.value != '0 && th_q > lim) ? lim : th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1v_q <= 1'b0;
      t2v_q <= 1'b0;
    end else if (en_i) begin
      t1v_q <= sv_q[SQ_STEPS-1];
      t2v_q <= t1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q <= 58'(sprod_q[SQ_STEPS-1][63:32] * r);
      lo_q <= 58'(sprod_q[SQ_STEPS-1][31:0] * r);
      th_q <= THETA_W'((59'(hi_q) + 59'(lo_q >> 32)) >> 14);
    end
  end

  // reduction modulo 2pi, one compare-subtract per stage
  logic               mv_q [MOD_STEPS+1];
  logic [THETA_W-1:0] ma_q [MOD_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= 1'b0;
    end else if (en_i) begin
      mv_q[0] <= t2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0] <= th_clip;
    end
  end

  for (genvar m = 0; m < MOD_STEPS; m++) begin : g_mod
    localparam logic [THETA_W-1:0] Sub = THETA_W'(TWO_PI_Q24) << (MOD_STEPS - 1 - m);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[m+1] <= 1'b0;
      end else if (en_i) begin
        mv_q[m+1] <= mv_q[m];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ma_q[m+1] <= (ma_q[m] >= Sub) ? ma_q[m] - Sub : ma_q[m];
      end
    end
  end

  // fold into the first quadrant, then CORDIC rotation
  logic [A_W-1:0] a0, a1, a2;
  logic           fneg;

  always_comb begin
    a0   = ma_q[MOD_STEPS][A_W-1:0];
    a1   = (a0 > PI_Q24) ? TWO_PI_Q24 - a0 : a0;
    fneg = a1 > HALF_PI_Q24;
    a2   = fneg ? PI_Q24 - a1 : a1;
  end

  logic                 cv_q [COS_ITERATIONS+1];
  logic                 cn_q [COS_ITERATIONS+1];
  logic signed [CW-1:0] cx_q [COS_ITERATIONS+1];
  logic signed [CW-1:0] cy_q [COS_ITERATIONS+1];
  logic signed [CW-1:0] cz_q [COS_ITERATIONS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en_i) begin
      cv_q[0] <= mv_q[MOD_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cn_q[0] <= fneg;
      cx_q[0] <= GAIN_Q30;
      cy_q[0] <= '0;
      cz_q[0] <= signed'(CW'(a2) << 6);
    end
  end

  for (genvar i = 0; i < COS_ITERATIONS; i++) begin : g_rot
    localparam logic signed [CW-1:0] Ang = CW'(ROT_ANGLE[i]);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        cv_q[i+1] <= cv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cn_q[i+1] <= cn_q[i];
        if (cz_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - Ang;
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + Ang;
        end
      end
    end
  end

  // round to Q1.16, cube, clip
  logic signed [CW-1:0] xf;
  logic [CW-1:0]        magx;
  logic [19:0]          mr;
  logic                 pneg;

  always_comb begin
    xf   = cx_q[COS_ITERATIONS];
    pneg = cn_q[COS_ITERATIONS] ^ xf[CW-1];
    magx = xf[CW-1] ? CW'(-xf) : CW'(xf);
    mr   = 20'((magx + 34'd8192) >> 14);
  end

  logic        p1v_q, p2v_q, p3v_q, p4v_q;
  logic        p1n_q, p2n_q, p3n_q;
  logic [16:0] mg_q, mg2_q;
  logic [33:0] sq_q;
  logic [50:0] cube_q;
  logic signed [17:0] gain_q;

  logic [50:0] qf;
  logic [16:0] qs;
  logic [17:0] fl, fl_sat;
  logic signed [17:0] gain_d;

  always_comb begin
    qf     = (cube_q + (51'd1 << 31)) >> 32;
    qs     = (qf > 51'(ONE_Q16)) ? ONE_Q16 : qf[16:0];
    fl     = (18'(qs) < clip_i.value) ? clip_i.value : 18'(qs);
    fl_sat = (fl > 18'(ONE_Q16)) ? 18'(ONE_Q16) : fl;
    if (clip_i.mode == CLIP_FLOOR) begin
      gain_d = signed'(fl_sat);
    end else if (p3n_q) begin
      gain_d = -signed'(18'(qs));
    end else begin
      gain_d = signed'(18'(qs));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q <= 1'b0;
      p2v_q <= 1'b0;
      p3v_q <= 1'b0;
      p4v_q <= 1'b0;
    end else if (en_i) begin
      p1v_q <= cv_q[COS_ITERATIONS];
      p2v_q <= p1v_q;
      p3v_q <= p2v_q;
      p4v_q <= p3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1n_q  <= pneg;
      mg_q   <= (mr > 20'(ONE_Q16)) ? ONE_Q16 : mr[16:0];
      p2n_q  <= p1n_q;
      sq_q   <= 34'(mg_q * mg_q);
      mg2_q  <= mg_q;
      p3n_q  <= p2n_q;
      cube_q <= 51'(sq_q * mg2_q);
      gain_q <= gain_d;
    end
  end

  assign valid_o = p4v_q;
  assign gain_o  = gain_q;

endmodule

[rtl/cos_cubed_beam_gain_unit.sv]
`timescale 1ns / 1ps
// channel  dir  beat
// in_i     in   source_l, source_m, frequency_hz
// out_o    out  beam_x, beam_y
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One beat per cycle in, one per cycle out unless the output stalls or the
// weight divider is busy. Stages: front 6, square root 26, argument 3, modulo 19,
// fold 1, CORDIC, cube 4, out 1. A write to REG_ELL_X or REG_ELL_Y reruns the
// weight divider, one quotient bit per divide cycle, with in_i.ready low meanwhile.
// Reset clears all config registers and valid bits; weights come up at unity.
// A stalled output holds the whole pipe; a skid stage keeps in_i.ready registered.
module cos_cubed_beam_gain_unit import ccbg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ccbg_in_if.sink               in_i,
  ccbg_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "cos_cubed_beam_gain_unit_assert.svh"

  logic [31:0]        bf_q;
  logic [1:0]         clip_mode_q;
  logic [17:0]        clip_value_q;
  logic signed [23:0] pl_q, pm_q;
  logic               ell_q;
  logic signed [15:0] ex_q, ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bf_q         <= '0;
      clip_mode_q  <= CLIP_NONE;
      clip_value_q <= '0;
      pl_q         <= '0;
      pm_q         <= '0;
      ell_q        <= 1'b0;
      ex_q         <= '0;
      ey_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BEAM_FACTOR: bf_q         <= cfg_data_i;
        REG_CLIP_MODE:   clip_mode_q  <= cfg_data_i[1:0];
        REG_CLIP_VALUE:  clip_value_q <= cfg_data_i[17:0];
        REG_POINT_L:     pl_q         <= signed'(cfg_data_i[23:0]);
        REG_POINT_M:     pm_q         <= signed'(cfg_data_i[23:0]);
        REG_ELL_EN:      ell_q        <= cfg_data_i[0];
        REG_ELL_X:       ex_q         <= signed'(cfg_data_i[15:0]);
        REG_ELL_Y:       ey_q         <= signed'(cfg_data_i[15:0]);
      endcase
    end
  end

  ccbg_wgt_t wgt;
  logic      wstart;

  assign wstart = cfg_we_i && (cfg_idx_i == REG_ELL_X || cfg_idx_i == REG_ELL_Y);

  ccbg_wgen u_wgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wstart),
    .ex_i    (ex_q),
    .ey_i    (ey_q),
    .wgt_o   (wgt)
  );

  logic adv, accept, push;
  logic lx_v, ly_v;
  logic signed [17:0] gx, gy;
  logic out_v_q, skid_v_q;

  assign adv        = !lx_v || !skid_v_q;
  assign in_i.ready = adv && !wgt.busy;
  assign accept     = in_i.valid && in_i.ready;
  assign push       = adv && lx_v;

  // front end: offsets, squares, weighted radius squared
  logic [5:0]         v_q;
  logic signed [24:0] dl_q, dm_q;
  logic [31:0]        f_q;
  logic [24:0]        al_q, am_q;
  logic [PROD_W-1:0]  prod1_q, prod2_q, prod3_q, prod4_q, prod5_q;
  logic [48:0]        l2_q, m2_q;
  logic [40:0]        plo_q [4];
  logic [41:0]        phi_q [4];
  logic [49:0]        s3_q, s4_q;
  logic [R2_W-1:0]    t_q [4];
  logic [R2_W-1:0]    rx_q, ry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q    <= 25'(in_i.source_l) - 25'(pl_q);
      dm_q    <= 25'(in_i.source_m) - 25'(pm_q);
      f_q     <= in_i.frequency_hz;
      al_q    <= dl_q[24] ? 25'(-dl_q) : 25'(dl_q);
      am_q    <= dm_q[24] ? 25'(-dm_q) : 25'(dm_q);
      prod1_q <= PROD_W'(bf_q * f_q);
      l2_q    <= 49'(al_q * al_q);
      m2_q    <= 49'(am_q * am_q);
      prod2_q <= prod1_q;
      for (int k = 0; k < 4; k++) begin
        plo_q[k] <= 41'(((k % 2 == 0) ? l2_q[23:0] : m2_q[23:0]) * wgt.w[k]);
        phi_q[k] <= 42'(((k % 2 == 0) ? l2_q[48:24] : m2_q[48:24]) * wgt.w[k]);
      end
      s3_q    <= 50'(l2_q) + 50'(m2_q);
      prod3_q <= prod2_q;
      for (int k = 0; k < 4; k++) begin
        t_q[k] <= R2_W'(({phi_q[k], 24'b0} + 66'(plo_q[k]) + 66'd8192) >> 14);
      end
      s4_q    <= s3_q;
      prod4_q <= prod3_q;
      rx_q    <= ell_q ? t_q[0] + t_q[1] : R2_W'(s4_q);
      ry_q    <= ell_q ? t_q[2] + t_q[3] : R2_W'(s4_q);
      prod5_q <= prod4_q;
    end
  end

  ccbg_clip_t clip;
  assign clip.mode  = clip_mode_q;
  assign clip.value = clip_value_q;

  ccbg_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_q[5]),
    .r2_i    (rx_q),
    .prod_i  (prod5_q),
    .clip_i  (clip),
    .valid_o (lx_v),
    .gain_o  (gx)
  );

  ccbg_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_q[5]),
    .r2_i    (ry_q),
    .prod_i  (prod5_q),
    .clip_i  (clip),
    .valid_o (ly_v),
    .gain_o  (gy)
  );

  // output register with skid beat
  logic signed [17:0] bx_q, by_q, sbx_q, sby_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_o.ready || !out_v_q) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_o.ready || !out_v_q) begin
      if (skid_v_q) begin
        bx_q <= sbx_q;
        by_q <= sby_q;
      end else if (push) begin
        bx_q <= gx;
        by_q <= gy;
      end
    end else if (push) begin
      sbx_q <= gx;
      sby_q <= gy;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.beam_x = bx_q;
  assign out_o.beam_y = by_q;

  `CCBG_ASSERT_IMP(a_lane_sync, 1'b1, lx_v == ly_v)
  `CCBG_ASSERT_NXT(a_wgt_start, wstart, wgt.busy)
  `CCBG_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
  `CCBG_ASSERT_IMP(a_gain_range, out_v_q, bx_q <= 18'sd65536 && bx_q >= -18'sd65536)

endmodule
